>>> hdl/ostp_pkg.sv
// shared types and constants of the one-shot timer pool
`timescale 1ns / 1ps

package ostp_pkg;

  localparam int TIME_W        = 48;
  localparam int INC_W         = 24;
  localparam int DUR_W         = 32;
  localparam int TAG_W         = 16;
  localparam int SLOT_W        = 2;
  localparam int NUM_SLOTS_DEF = 3;
  localparam int MAX_FIRES     = 3;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};
  localparam logic [INC_W-1:0]  INC_RESET = 24'd279508;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_TICK   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_INSERTED = 3'd0,
    KIND_FULL     = 3'd1,
    KIND_FIRED    = 3'd2,
    KIND_ACK      = 3'd3,
    KIND_IDLE     = 3'd4
  } kind_e;

  // input request as it arrives on the port
  typedef struct packed {
    logic [1:0]        operation;
    logic [DUR_W-1:0]  duration;
    logic [TAG_W-1:0]  tag;
    logic [SLOT_W-1:0] slot;
  } req_t;

  // classified command handed from front to back
  typedef struct packed {
    op_e               op;
    logic [DUR_W-1:0]  duration;
    logic [TAG_W-1:0]  tag;
    logic [SLOT_W-1:0] slot;
    logic              slot_ok;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [2:0]        kind;
    logic [SLOT_W-1:0] slot_index;
    logic [TAG_W-1:0]  fired_tag;
    logic [TIME_W-1:0] current_time;
    logic              last;
  } res_t;

endpackage

>>> hdl/ostp_front.sv
// front end: takes requests and classifies them into commands
`timescale 1ns / 1ps

module ostp_front #(
  parameter int NUM_SLOTS = ostp_pkg::NUM_SLOTS_DEF
) (
  input  logic          req_valid,
  output logic          req_stall,
  input  ostp_pkg::req_t req,
  input  logic          q_full,
  output logic          q_push,
  output ostp_pkg::cmd_t q_cmd
);

  assign req_stall = q_full;
  assign q_push    = req_valid && !q_full;

  always_comb begin
    q_cmd          = '0;
    q_cmd.op       = ostp_pkg::op_e'(req.operation);
    q_cmd.duration = req.duration;
    q_cmd.tag      = req.tag;
    q_cmd.slot     = req.slot;
    // slots beyond the pool are flagged here so the back end ignores their deletes
    q_cmd.slot_ok  = (int'(req.slot) < NUM_SLOTS);
  end

endmodule

>>> hdl/ostp_queue.sv
// short command queue between front and back
`timescale 1ns / 1ps

module ostp_queue #(
  parameter int DEPTH = ostp_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ostp_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output ostp_pkg::cmd_t pop_cmd,
  output logic           empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ostp_pkg::cmd_t entries [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/ostp_back.sv
// back end: slot table, time counter and result generation
`timescale 1ns / 1ps

module ostp_back #(
  parameter int NUM_SLOTS = ostp_pkg::NUM_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  ostp_pkg::cmd_t              q_cmd,
  output logic                        q_pop,
  input  logic                        cfg_we,
  input  logic [ostp_pkg::INC_W-1:0]  cfg_data,
  output logic                        res_valid,
  input  logic                        res_stall,
  output ostp_pkg::res_t              res
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(ostp_pkg::MAX_FIRES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_ACK,
    S_ADD,
    S_SCAN,
    S_FIRE
  } state_t;

  state_t                         state;
  ostp_pkg::cmd_t                 cur;
  logic [ostp_pkg::INC_W-1:0]     inc;
  logic [ostp_pkg::TIME_W-1:0]    now;
  logic [NUM_SLOTS-1:0]           busy;
  logic [ostp_pkg::TIME_W-1:0]    deadline [NUM_SLOTS];
  logic [ostp_pkg::TAG_W-1:0]     tag_mem  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]           exp_mask;
  logic [IDX_W-1:0]               scan_idx;
  logic [CNT_W-1:0]               fire_cnt;

  logic                           res_free;
  logic                           emit;
  ostp_pkg::res_t                 res_next;
  logic                           free_found;
  logic [IDX_W-1:0]               free_idx;
  logic [IDX_W-1:0]               pick_idx;
  logic [NUM_SLOTS-1:0]           pick_mask;
  logic [NUM_SLOTS-1:0]           rest_mask;
  logic [NUM_SLOTS-1:0]           del_mask;
  logic                           fire_last;
  logic [ostp_pkg::TIME_W:0]      ins_sum;
  logic [ostp_pkg::TIME_W-1:0]    ins_deadline;
  logic [ostp_pkg::TIME_W:0]      tick_sum;
  logic [ostp_pkg::TIME_W-1:0]    now_next;

  assign res_free = !res_valid || !res_stall;
  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign emit     = res_free && (state == S_INSERT || state == S_ACK || state == S_FIRE);

  // saturating adders
  assign ins_sum      = {1'b0, now} + (ostp_pkg::TIME_W + 1)'(cur.duration);
  assign ins_deadline = ins_sum[ostp_pkg::TIME_W] ? ostp_pkg::TIME_MAX
                                                  : ins_sum[ostp_pkg::TIME_W-1:0];
  assign tick_sum     = {1'b0, now} + (ostp_pkg::TIME_W + 1)'(inc);
  assign now_next     = tick_sum[ostp_pkg::TIME_W] ? ostp_pkg::TIME_MAX
                                                   : tick_sum[ostp_pkg::TIME_W-1:0];

  // lowest free slot, lowest pending fire, delete mask
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    pick_idx   = '0;
    pick_mask  = '0;
    del_mask   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
      if (exp_mask[i]) begin
        pick_idx  = IDX_W'(i);
        pick_mask = NUM_SLOTS'(1) << i;
      end
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      del_mask[i] = cur.slot_ok && (int'(cur.slot) == i);
    end
  end

  assign rest_mask = exp_mask & ~pick_mask;
  assign fire_last = (rest_mask == '0) || (fire_cnt == CNT_W'(ostp_pkg::MAX_FIRES - 1));

  always_comb begin
    res_next              = '0;
    res_next.current_time = now;
    res_next.kind         = ostp_pkg::KIND_ACK;
    res_next.last         = 1'b1;
    case (state)
      S_INSERT: begin
        if (free_found) begin
          res_next.kind       = ostp_pkg::KIND_INSERTED;
          res_next.slot_index = ostp_pkg::SLOT_W'(free_idx);
        end else begin
          res_next.kind = ostp_pkg::KIND_FULL;
        end
      end
      S_FIRE: begin
        if (exp_mask == '0) begin
          res_next.kind = ostp_pkg::KIND_IDLE;
        end else begin
          res_next.kind       = ostp_pkg::KIND_FIRED;
          res_next.slot_index = ostp_pkg::SLOT_W'(pick_idx);
          res_next.fired_tag  = tag_mem[pick_idx];
          res_next.last       = fire_last;
        end
      end
      default: begin
        res_next.kind = ostp_pkg::KIND_ACK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      inc       <= ostp_pkg::INC_RESET;
      now       <= '0;
      busy      <= '0;
      exp_mask  <= '0;
      scan_idx  <= '0;
      fire_cnt  <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        inc <= cfg_data;
      end

      if (emit) begin
        res_valid <= 1'b1;
        res       <= res_next;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur <= q_cmd;
            case (q_cmd.op)
              ostp_pkg::OP_INSERT: state <= S_INSERT;
              ostp_pkg::OP_TICK:   state <= S_ADD;
              default:             state <= S_ACK;
            endcase
          end
        end
        S_INSERT: begin
          if (res_free) begin
            if (free_found) begin
              busy[free_idx]     <= 1'b1;
              deadline[free_idx] <= ins_deadline;
              tag_mem[free_idx]  <= cur.tag;
            end
            state <= S_IDLE;
          end
        end
        S_ACK: begin
          if (res_free) begin
            if (cur.op == ostp_pkg::OP_CLEAR) begin
              busy <= '0;
            end else begin
              busy <= busy & ~del_mask;
            end
            state <= S_IDLE;
          end
        end
        S_ADD: begin
          now      <= now_next;
          scan_idx <= '0;
          exp_mask <= '0;
          fire_cnt <= '0;
          state    <= S_SCAN;
        end
        S_SCAN: begin
          // one deadline compare per cycle
          exp_mask[scan_idx] <= busy[scan_idx] && (now >= deadline[scan_idx]);
          if (scan_idx == IDX_W'(NUM_SLOTS - 1)) begin
            state <= S_FIRE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_FIRE: begin
          if (res_free) begin
            if (exp_mask == '0) begin
              state <= S_IDLE;
            end else begin
              busy     <= busy & ~pick_mask;
              exp_mask <= rest_mask;
              fire_cnt <= fire_cnt + 1'b1;
              if (fire_last) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/one_shot_timer_pool.sv
// top level of the one-shot timer pool
`timescale 1ns / 1ps

// Pool of NUM_SLOTS one-shot timers over a 48-bit saturating time counter in
// units of 2^-24 s. A request is insert (claims the lowest free slot with
// deadline now plus duration, or answers pool full), delete (frees one slot,
// out-of-range slots ignored), clear (frees all slots) or tick (adds the
// tick_increment register to now, then fires expired busy slots in slot order,
// at most three per tick; further expired slots fire on a later tick). Every
// request yields one or more results, the final one flagged by last. The front
// end classifies requests into a two-entry command queue, so a few requests
// can be taken while the back end works; the back end runs one command at a
// time. A tick adds the increment, then scans the slots with the single shared
// deadline comparator that visits one slot per cycle, then emits its results. A
// finished result sits in an output register so the back end can go on to its
// next command while it waits to be taken, though it stalls on a further result.
// The configuration port is always ready; write it only while no request is in
// flight.

module one_shot_timer_pool #(
  parameter int NUM_SLOTS = ostp_pkg::NUM_SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // request channel
  input  logic                       req_valid,
  output logic                       req_stall,
  input  ostp_pkg::req_t             req,
  // result channel
  output logic                       res_valid,
  input  logic                       res_stall,
  output ostp_pkg::res_t             res,
  // tick_increment write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ostp_pkg::INC_W-1:0] cfg_data
);

  // front to queue
  logic           push;
  ostp_pkg::cmd_t push_cmd;
  logic           q_full;
  // queue to back
  logic           pop;
  ostp_pkg::cmd_t pop_cmd;
  logic           q_empty;

  // register writes never wait
  assign cfg_ready = 1'b1;

  ostp_front #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_front (
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_full    (q_full),
    .q_push    (push),
    .q_cmd     (push_cmd)
  );

  ostp_queue #(
    .DEPTH (ostp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  // slot table, time counter and output register
  ostp_back #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_cmd     (pop_cmd),
    .q_pop     (pop),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

>>> sim/testbench.sv
// self-checking testbench of the one-shot timer pool
`timescale 1ns / 1ps

module testbench;

  localparam int N_SLOTS     = ostp_pkg::NUM_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_PRINTED = 40;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       req_valid = 1'b0;
  logic                       req_stall;
  ostp_pkg::req_t             req       = '0;
  logic                       res_valid;
  logic                       res_stall = 1'b0;
  ostp_pkg::res_t             res;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [ostp_pkg::INC_W-1:0] cfg_data  = '0;

  // predicted pool state, advanced on every accepted request
  logic [ostp_pkg::TIME_W-1:0] pool_now;
  logic [ostp_pkg::INC_W-1:0]  pool_inc;
  logic                        pool_busy     [N_SLOTS];
  logic [ostp_pkg::TIME_W-1:0] pool_deadline [N_SLOTS];
  logic [ostp_pkg::TAG_W-1:0]  pool_tag      [N_SLOTS];

  ostp_pkg::res_t expected_results [$];
  ostp_pkg::res_t want;
  int   mismatch_count = 0;
  int   results_seen   = 0;
  int   cycle_count    = 0;
  int   stall_left     = 0;
  bit   req_gaps_on    = 1'b1;
  bit   res_stall_on   = 1'b1;

  one_shot_timer_pool #(
    .NUM_SLOTS(N_SLOTS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (rst || !res_stall_on) begin
      res_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      res_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      res_stall  <= 1'b1;
      stall_left <= pick_gap();
    end else begin
      res_stall <= 1'b0;
    end
  end

  task automatic report_mismatch(string what);
    if (mismatch_count < MAX_PRINTED)
      $display("[%0t] result %0d: %s", $time, results_seen, what);
    mismatch_count++;
  endtask

  // compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result, kind %0d", res.kind));
      end else begin
        want = expected_results.pop_front();
        if (res.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", res.kind, want.kind));
        if (res.slot_index !== want.slot_index)
          report_mismatch($sformatf("slot_index %0d, expected %0d", res.slot_index,
                                    want.slot_index));
        if (res.fired_tag !== want.fired_tag)
          report_mismatch($sformatf("fired_tag %h, expected %h", res.fired_tag,
                                    want.fired_tag));
        if (res.current_time !== want.current_time)
          report_mismatch($sformatf("current_time %h, expected %h", res.current_time,
                                    want.current_time));
        if (res.last !== want.last)
          report_mismatch($sformatf("last %b, expected %b", res.last, want.last));
      end
      results_seen++;
    end
  end

  function automatic logic [ostp_pkg::TIME_W-1:0] time_sat_add(
      logic [ostp_pkg::TIME_W-1:0] a, logic [ostp_pkg::DUR_W-1:0] b);
    logic [ostp_pkg::TIME_W:0] sum;
    sum = {1'b0, a} + (ostp_pkg::TIME_W + 1)'(b);
    return sum[ostp_pkg::TIME_W] ? ostp_pkg::TIME_MAX : sum[ostp_pkg::TIME_W-1:0];
  endfunction

  function automatic ostp_pkg::res_t make_result(ostp_pkg::kind_e k, int idx,
                                                 logic [ostp_pkg::TAG_W-1:0] t);
    ostp_pkg::res_t r;
    r.kind         = k;
    r.slot_index   = idx[ostp_pkg::SLOT_W-1:0];
    r.fired_tag    = t;
    r.current_time = pool_now;
    r.last         = 1'b0;
    return r;
  endfunction

  // works out the results of one request and advances the pool state
  task automatic predict_timer_results(ostp_pkg::req_t r);
    ostp_pkg::res_t outs [ostp_pkg::MAX_FIRES];
    int             n;
    int             pick;
    n    = 0;
    pick = -1;
    case (r.operation)
      ostp_pkg::OP_INSERT: begin
        for (int i = N_SLOTS - 1; i >= 0; i--)
          if (!pool_busy[i]) pick = i;
        if (pick >= 0) begin
          pool_busy[pick]     = 1'b1;
          pool_deadline[pick] = time_sat_add(pool_now, r.duration);
          pool_tag[pick]      = r.tag;
          outs[n] = make_result(ostp_pkg::KIND_INSERTED, pick, '0);
        end else begin
          outs[n] = make_result(ostp_pkg::KIND_FULL, 0, '0);
        end
        n++;
      end
      ostp_pkg::OP_DELETE: begin
        // out-of-range slot is ignored but still acknowledged
        if (r.slot < N_SLOTS) pool_busy[r.slot] = 1'b0;
        outs[n] = make_result(ostp_pkg::KIND_ACK, 0, '0);
        n++;
      end
      ostp_pkg::OP_CLEAR: begin
        for (int i = 0; i < N_SLOTS; i++) pool_busy[i] = 1'b0;
        outs[n] = make_result(ostp_pkg::KIND_ACK, 0, '0);
        n++;
      end
      default: begin
        // tick
        pool_now = time_sat_add(pool_now, ostp_pkg::DUR_W'(pool_inc));
        for (int i = 0; i < N_SLOTS; i++) begin
          if (n < ostp_pkg::MAX_FIRES && pool_busy[i] && pool_now >= pool_deadline[i]) begin
            pool_busy[i] = 1'b0;
            outs[n] = make_result(ostp_pkg::KIND_FIRED, i, pool_tag[i]);
            n++;
          end
        end
        if (n == 0) begin
          outs[n] = make_result(ostp_pkg::KIND_IDLE, 0, '0);
          n++;
        end
      end
    endcase
    outs[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_results.push_back(outs[i]);
  endtask

  // hands one request to the block; valid stays high for a back-to-back request
  task automatic push_request(ostp_pkg::req_t r);
    int gap;
    gap = req_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predict_timer_results(r);
  endtask

  // sender holds off until every predicted result has come back
  task automatic wait_for_drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_tick_increment(logic [ostp_pkg::INC_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pool_inc = v;
  endtask

  function automatic ostp_pkg::req_t make_request(ostp_pkg::op_e op,
                                                  logic [ostp_pkg::DUR_W-1:0] dur,
                                                  logic [ostp_pkg::TAG_W-1:0] t,
                                                  logic [ostp_pkg::SLOT_W-1:0] s);
    ostp_pkg::req_t r;
    r.operation = op;
    r.duration  = dur;
    r.tag       = t;
    r.slot      = s;
    return r;
  endfunction

  function automatic logic [ostp_pkg::TAG_W-1:0] rand_tag();
    return ostp_pkg::TAG_W'($urandom());
  endfunction

  // durations mostly within a few ticks so timers actually fire, some on or one
  // unit off a tick boundary, a few anywhere in the 32-bit range
  function automatic logic [ostp_pkg::DUR_W-1:0] timer_duration();
    logic [63:0] steps;
    int          roll;
    roll  = $urandom_range(0, 99);
    steps = 64'($urandom_range(0, 4));
    if (roll < 15) return $urandom();
    if (roll < 35)
      return ostp_pkg::DUR_W'(steps * pool_inc + $urandom_range(0, 2) - 1);
    return ostp_pkg::DUR_W'($urandom() % (64'd5 * pool_inc + 1));
  endfunction

  function automatic ostp_pkg::req_t random_request();
    ostp_pkg::req_t r;
    int             roll;
    r    = make_request(ostp_pkg::OP_TICK, $urandom(), rand_tag(),
                        ostp_pkg::SLOT_W'($urandom_range(0, 3)));
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      r.operation = ostp_pkg::OP_INSERT;
      r.duration  = timer_duration();
    end else if (roll < 50) begin
      r.operation = ostp_pkg::OP_DELETE;
      r.slot = ($urandom_range(0, 9) == 0) ? 2'd3
                                           : ostp_pkg::SLOT_W'($urandom_range(0, N_SLOTS - 1));
    end else if (roll < 57) begin
      r.operation = ostp_pkg::OP_CLEAR;
    end
    return r;
  endfunction

  task automatic test_traffic(int count);
    for (int i = 0; i < count; i++) begin
      // now and then let the pool go fully quiet before going on
      if ($urandom_range(0, 49) == 0) wait_for_drain();
      push_request(random_request());
    end
  endtask

  // field extremes, every operation and the corner cases of the pool
  task automatic test_directed_cases();
    push_request(make_request(ostp_pkg::OP_INSERT, '0, '0, 2'd0));
    push_request(make_request(ostp_pkg::OP_INSERT, '1, '1, 2'd3));
    // deadline exactly one tick away fires on the first tick
    push_request(make_request(ostp_pkg::OP_INSERT, ostp_pkg::DUR_W'(ostp_pkg::INC_RESET),
                              16'h1234, 2'd1));
    push_request(make_request(ostp_pkg::OP_INSERT, 32'h1, 16'hbeef, 2'd0));
    push_request(make_request(ostp_pkg::OP_TICK, $urandom(), rand_tag(), 2'd2));
    push_request(make_request(ostp_pkg::OP_DELETE, $urandom(), rand_tag(), 2'd1));
    // delete of a slot already free
    push_request(make_request(ostp_pkg::OP_DELETE, $urandom(), rand_tag(), 2'd1));
    // delete beyond the last slot
    push_request(make_request(ostp_pkg::OP_DELETE, $urandom(), rand_tag(), 2'd3));
    push_request(make_request(ostp_pkg::OP_TICK, '1, '1, 2'd3));
    // three expiries on one tick
    push_request(make_request(ostp_pkg::OP_INSERT, '0, 16'haaaa, 2'd2));
    push_request(make_request(ostp_pkg::OP_INSERT, 32'h1, 16'h5555, 2'd1));
    push_request(make_request(ostp_pkg::OP_INSERT, ostp_pkg::DUR_W'(ostp_pkg::INC_RESET),
                              16'h0f0f, 2'd0));
    push_request(make_request(ostp_pkg::OP_TICK, '0, '0, 2'd0));
    // one unit past the tick boundary waits a tick longer
    push_request(make_request(ostp_pkg::OP_INSERT,
                              ostp_pkg::DUR_W'(ostp_pkg::INC_RESET) + 1, 16'hf0f0, 2'd2));
    push_request(make_request(ostp_pkg::OP_TICK, $urandom(), rand_tag(), 2'd1));
    push_request(make_request(ostp_pkg::OP_TICK, $urandom(), rand_tag(), 2'd0));
    push_request(make_request(ostp_pkg::OP_INSERT, '0, 16'h0001, 2'd3));
    push_request(make_request(ostp_pkg::OP_INSERT, 32'h8000_0000, 16'h8000, 2'd0));
    push_request(make_request(ostp_pkg::OP_CLEAR, '1, '1, 2'd3));
    push_request(make_request(ostp_pkg::OP_TICK, $urandom(), rand_tag(), 2'd2));
    push_request(make_request(ostp_pkg::OP_DELETE, '0, '0, 2'd0));
    push_request(make_request(ostp_pkg::OP_DELETE, '1, '1, 2'd2));
    push_request(make_request(ostp_pkg::OP_CLEAR, '0, '0, 2'd0));
  endtask

  // new increment once the pool has gone quiet, then a burst of traffic
  task automatic run_increment_phase(logic [ostp_pkg::INC_W-1:0] inc, int count, bit gaps,
                                     bit stalls);
    wait_for_drain();
    write_tick_increment(inc);
    req_gaps_on  = gaps;
    res_stall_on = stalls;
    test_traffic(count);
  endtask

  task automatic test_increment_extremes();
    run_increment_phase(24'd1, 40, 1'b1, 1'b1);
    run_increment_phase({ostp_pkg::INC_W{1'b1}}, 50, 1'b0, 1'b0);
    // zero increment: time stands still, deadlines still checked
    run_increment_phase('0, 30, 1'b1, 1'b0);
    run_increment_phase(ostp_pkg::INC_RESET, 20, 1'b0, 1'b1);
  endtask

  task automatic test_random_increments();
    for (int i = 0; i < 3; i++)
      run_increment_phase(ostp_pkg::INC_W'($urandom_range(1, (1 << ostp_pkg::INC_W) - 1)),
                          40, 1'b1, i != 1);
  endtask

  initial begin
    pool_now = '0;
    pool_inc = ostp_pkg::INC_RESET;
    for (int i = 0; i < N_SLOTS; i++) begin
      pool_busy[i]     = 1'b0;
      pool_deadline[i] = '0;
      pool_tag[i]      = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_traffic(100);
    test_increment_extremes();
    test_random_increments();

    wait_for_drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
